// ----- rtl/core/drs_pkg.sv -----
`default_nettype none

package drs_pkg;

   localparam int FIELD_WIDTH   = 32;
   localparam int FOURIER_WIDTH = 18;
   localparam int DECAY_WIDTH   = 16;
   localparam int COEF_FRAC     = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CMD_DEPTH     = 4;
   localparam int OUT_DEPTH     = 4;
   localparam int OUT_COUNT_WIDTH = $clog2(OUT_DEPTH) + 1;

   typedef enum logic [1:0] {
      REG_FOURIER,
      REG_DECAY,
      REG_LEFT,
      REG_RIGHT
   } reg_index_type;

   typedef enum logic [1:0] {
      PTS_NONE,
      PTS_ONE,
      PTS_MANY
   } point_state_type;

   typedef struct packed {
      logic left_en;
      logic int_en;
      logic right_en;
   } cmd_flags_type;

endpackage

`default_nettype wire

// ----- rtl/core/diffusion_reaction_stencil_step.sv -----
// One explicit diffusion-reaction time step over a streamed row of grid points.
// Input queue side: req_concentration and req_row_end are taken when push is
// high and full is low; req_row_end marks the last point of a row.
// Result queue side: while empty is low the oldest result sits on the rsp_
// ports and is taken when pop is high. A row of n points gives n results:
// left_boundary first, right_boundary last with rsp_row_done set, and each
// interior value once its right neighbor has arrived. rsp_run_last flags the
// last result caused by one input transaction.
// Throughput: one input transaction per cycle while full is low; a row-end
// point that also completes an interior value issues two results through the
// shared arithmetic pipe.
// Each result passes through the command queue, the laplacian and decay
// product register, the gain product register with clamp and the result
// queue before it is visible on the rsp_ ports.
// Configuration registers sit at byte addresses 0, 4, 8 and 12 and must be
// written only while the block is idle; the block itself does not enforce this.
// Reset empties both queues and clears the row state and the registers.
// A stalled receiver fills the 4-entry result queue, then the 4-entry command
// queue, after which full rises.
`default_nettype none

module diffusion_reaction_stencil_step #(
   parameter int CONC_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output logic                                      full,
   input  wire logic [drs_pkg::FIELD_WIDTH-1:0]      req_concentration,
   input  wire logic                                 req_row_end,
   output logic                                      empty,
   input  wire logic                                 pop,
   output logic [drs_pkg::FIELD_WIDTH-1:0]           rsp_new_concentration,
   output logic                                      rsp_row_done,
   output logic                                      rsp_run_last,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [drs_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [31:0]                          pwdata,
   output logic [31:0]                               prdata,
   output logic                                      pready
);

   localparam int W  = CONC_WIDTH;
   localparam int CDW = 3 * W + $bits(drs_pkg::cmd_flags_type);

   logic [drs_pkg::FOURIER_WIDTH-1:0] fourier_ff;
   logic [drs_pkg::DECAY_WIDTH-1:0]   decay_ff;
   logic [drs_pkg::FIELD_WIDTH-1:0]   left_ff;
   logic [drs_pkg::FIELD_WIDTH-1:0]   right_ff;
   drs_pkg::reg_index_type            reg_index;
   logic                              csr_write;

   logic                   cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [W-1:0]           f_prev, f_mid, f_next;
   drs_pkg::cmd_flags_type f_flags;
   logic [CDW-1:0]         cmd_wdata, cmd_rdata;
   logic [$clog2(drs_pkg::CMD_DEPTH):0] cmd_count;

   logic                   out_push, out_full;
   logic [W+1:0]           out_wdata, out_rdata;
   logic [drs_pkg::OUT_COUNT_WIDTH-1:0] out_count;

   // register port
   assign pready    = 1'b1;
   assign reg_index = drs_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      case (reg_index)
         drs_pkg::REG_FOURIER: prdata = 32'(fourier_ff);
         drs_pkg::REG_DECAY:   prdata = 32'(decay_ff);
         drs_pkg::REG_LEFT:    prdata = left_ff;
         drs_pkg::REG_RIGHT:   prdata = right_ff;
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fourier_ff <= '0;
         decay_ff   <= '0;
         left_ff    <= '0;
         right_ff   <= '0;
      end else if (csr_write) begin
         case (reg_index)
            drs_pkg::REG_FOURIER: fourier_ff <= pwdata[drs_pkg::FOURIER_WIDTH-1:0];
            drs_pkg::REG_DECAY:   decay_ff   <= pwdata[drs_pkg::DECAY_WIDTH-1:0];
            drs_pkg::REG_LEFT:    left_ff    <= pwdata;
            drs_pkg::REG_RIGHT:   right_ff   <= pwdata;
            default:              fourier_ff <= fourier_ff;
         endcase
      end
   end

   drs_front #(.CONC_WIDTH(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .conc      (W'(req_concentration)),
      .row_end   (req_row_end),
      .full      (full),
      .cmd_push  (cmd_push),
      .cmd_full  (cmd_full),
      .cmd_prev  (f_prev),
      .cmd_mid   (f_mid),
      .cmd_next  (f_next),
      .cmd_flags (f_flags)
   );

   assign cmd_wdata = {f_flags, f_prev, f_mid, f_next};

   drs_queue #(.DATA_WIDTH(CDW), .DEPTH(drs_pkg::CMD_DEPTH)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   drs_back #(.CONC_WIDTH(W)) u_back (
      .clock          (clock),
      .reset          (reset),
      .fourier_number (fourier_ff),
      .decay_per_step (decay_ff),
      .left_boundary  (W'(left_ff)),
      .right_boundary (W'(right_ff)),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .cmd_prev       (cmd_rdata[3*W-1:2*W]),
      .cmd_mid        (cmd_rdata[2*W-1:W]),
      .cmd_next       (cmd_rdata[W-1:0]),
      .cmd_flags      (drs_pkg::cmd_flags_type'(cmd_rdata[CDW-1:3*W])),
      .out_count      (out_count),
      .out_push       (out_push),
      .out_data       (out_wdata)
   );

   drs_queue #(.DATA_WIDTH(W + 2), .DEPTH(drs_pkg::OUT_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_rdata),
      .empty     (empty),
      .count     (out_count)
   );

   assign rsp_new_concentration = drs_pkg::FIELD_WIDTH'(out_rdata[W-1:0]);
   assign rsp_run_last          = out_rdata[W];
   assign rsp_row_done          = out_rdata[W+1];

   // no result may be dropped at the result queue
   assert property (@(posedge clock) disable iff (reset) !(out_push && out_full))
      else $error("result pushed into full result queue");

   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (cmd_count == '0 && empty))
      else $error("queues not empty after reset");

endmodule

`default_nettype wire

// ----- rtl/core/drs_queue.sv -----
`default_nettype none

module drs_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [DATA_WIDTH-1:0]      push_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic [DATA_WIDTH-1:0]           pop_data,
   output logic                            empty,
   output logic [$clog2(DEPTH):0]          count
);

   localparam int AW = $clog2(DEPTH);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign count   = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/drs_front.sv -----
`default_nettype none

module drs_front #(
   parameter int CONC_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire logic [CONC_WIDTH-1:0]   conc,
   input  wire logic                    row_end,
   output logic                         full,
   output logic                         cmd_push,
   input  wire logic                    cmd_full,
   output logic [CONC_WIDTH-1:0]        cmd_prev,
   output logic [CONC_WIDTH-1:0]        cmd_mid,
   output logic [CONC_WIDTH-1:0]        cmd_next,
   output drs_pkg::cmd_flags_type       cmd_flags
);

   drs_pkg::point_state_type state_ff, state_in;
   logic [CONC_WIDTH-1:0] older_ff, older_in;
   logic [CONC_WIDTH-1:0] middle_ff, middle_in;
   logic accept;

   assign full   = cmd_full;
   assign accept = push & ~cmd_full;

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (row_end) begin
            state_in = drs_pkg::PTS_NONE;
         end else begin
            case (state_ff)
               drs_pkg::PTS_NONE: state_in = drs_pkg::PTS_ONE;
               drs_pkg::PTS_ONE:  state_in = drs_pkg::PTS_MANY;
               drs_pkg::PTS_MANY: state_in = drs_pkg::PTS_MANY;
               default:           state_in = drs_pkg::PTS_NONE;
            endcase
         end
      end
   end

   // classification
   always_comb begin
      cmd_flags = '0;
      case (state_ff)
         drs_pkg::PTS_NONE: cmd_flags.left_en = ~row_end;
         drs_pkg::PTS_ONE:  cmd_flags.left_en = 1'b0;
         drs_pkg::PTS_MANY: cmd_flags.int_en  = 1'b1;
         default:           cmd_flags = '0;
      endcase
      cmd_flags.right_en = row_end;
      cmd_push = accept & (cmd_flags.left_en | cmd_flags.int_en | cmd_flags.right_en);
      cmd_prev = older_ff;
      cmd_mid  = middle_ff;
      cmd_next = conc;
   end

   always_comb begin
      older_in  = accept ? middle_ff : older_ff;
      middle_in = accept ? conc : middle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= drs_pkg::PTS_NONE;
         older_ff  <= '0;
         middle_ff <= '0;
      end else begin
         state_ff  <= state_in;
         older_ff  <= older_in;
         middle_ff <= middle_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/drs_back.sv -----
`default_nettype none

module drs_back #(
   parameter int CONC_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic [drs_pkg::FOURIER_WIDTH-1:0]      fourier_number,
   input  wire logic [drs_pkg::DECAY_WIDTH-1:0]        decay_per_step,
   input  wire logic [CONC_WIDTH-1:0]                  left_boundary,
   input  wire logic [CONC_WIDTH-1:0]                  right_boundary,
   input  wire logic                                   cmd_empty,
   output logic                                        cmd_pop,
   input  wire logic [CONC_WIDTH-1:0]                  cmd_prev,
   input  wire logic [CONC_WIDTH-1:0]                  cmd_mid,
   input  wire logic [CONC_WIDTH-1:0]                  cmd_next,
   input  wire drs_pkg::cmd_flags_type                 cmd_flags,
   input  wire logic [drs_pkg::OUT_COUNT_WIDTH-1:0]    out_count,
   output logic                                        out_push,
   output logic [CONC_WIDTH+1:0]                       out_data
);

   localparam int W   = CONC_WIDTH;
   localparam int LW  = W + 2;
   localparam int PW  = W + drs_pkg::FOURIER_WIDTH + 2;
   localparam int DW  = PW - drs_pkg::COEF_FRAC;
   localparam int CPW = W + drs_pkg::COEF_FRAC;
   localparam int VW  = W + 5;
   localparam int KW  = drs_pkg::OUT_COUNT_WIDTH + 1;

   logic second_ff, second_in;
   logic credit_ok, issue, do_int;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_int_ff;
   logic                 s1_done_ff;
   logic                 s1_last_ff;
   logic [W-1:0]         s1_conc_ff;
   logic [W-1:0]         s1_bval_ff;
   logic signed [LW-1:0] s1_lap_ff;
   logic [CPW-1:0]       s1_cprod_ff;
   logic [LW-1:0]        lap_in;
   logic [CPW-1:0]       cprod_in;
   logic [W-1:0]         bval_in;

   logic                 s2_valid_ff;
   logic                 s2_int_ff;
   logic                 s2_done_ff;
   logic                 s2_last_ff;
   logic [W-1:0]         s2_conc_ff;
   logic [W-1:0]         s2_bval_ff;
   logic signed [PW-1:0] s2_dprod_ff;
   logic [W-1:0]         s2_clear_ff;
   logic signed [PW-1:0] dprod_in;

   logic signed [DW-1:0] diff;
   logic signed [VW-1:0] sum;
   logic [W-1:0]         clamped;
   logic [W-1:0]         result;

   // results in flight plus queued must fit in the output queue
   assign credit_ok = (KW'(out_count) + KW'(s1_valid_ff) + KW'(s2_valid_ff))
                      < KW'(drs_pkg::OUT_DEPTH);
   assign issue  = ~cmd_empty & credit_ok;
   assign do_int = cmd_flags.int_en & ~second_ff;

   always_comb begin
      cmd_pop     = issue & ~(do_int & cmd_flags.right_en);
      second_in   = issue ? (do_int & cmd_flags.right_en) : second_ff;
      s1_valid_in = issue;
      lap_in      = {2'b00, cmd_prev} + {2'b00, cmd_next} - {1'b0, cmd_mid, 1'b0};
      cprod_in    = CPW'(decay_per_step) * CPW'(cmd_mid);
      bval_in     = cmd_flags.right_en ? right_boundary : left_boundary;
   end

   always_comb begin
      dprod_in = PW'(s1_lap_ff) * PW'($signed({1'b0, fourier_number}));
   end

   always_comb begin
      diff = s2_dprod_ff[PW-1:drs_pkg::COEF_FRAC];
      sum  = VW'($signed({1'b0, s2_conc_ff})) + VW'(diff)
             - VW'($signed({1'b0, s2_clear_ff}));
      if (sum[VW-1]) begin
         clamped = '0;
      end else if (sum[VW-2:W] != '0) begin
         clamped = '1;
      end else begin
         clamped = sum[W-1:0];
      end
      result   = s2_int_ff ? clamped : s2_bval_ff;
      out_push = s2_valid_ff;
      out_data = {s2_done_ff, s2_last_ff, result};
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_int_ff   <= do_int;
         s1_done_ff  <= ~do_int & cmd_flags.right_en;
         s1_last_ff  <= ~(do_int & cmd_flags.right_en);
         s1_conc_ff  <= cmd_mid;
         s1_bval_ff  <= bval_in;
         s1_lap_ff   <= $signed(lap_in);
         s1_cprod_ff <= cprod_in;
      end
      if (s1_valid_ff) begin
         s2_int_ff   <= s1_int_ff;
         s2_done_ff  <= s1_done_ff;
         s2_last_ff  <= s1_last_ff;
         s2_conc_ff  <= s1_conc_ff;
         s2_bval_ff  <= s1_bval_ff;
         s2_dprod_ff <= dprod_in;
         s2_clear_ff <= s1_cprod_ff[drs_pkg::COEF_FRAC +: W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         second_ff   <= second_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

endmodule

`default_nettype wire
